[design/luhn_pkg.sv]
// Shared types, constants and functions for the card number Luhn checker.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none
package luhn_pkg;

   localparam int NUMBER_BITS = 27;
   localparam int KIND_BITS   = 2;
   localparam int TOTAL_BITS  = 7;
   localparam int DIGIT_BITS  = 4;
   localparam int DIGITS      = 8;

   // divide by ten: q = (x * RECIP_TEN) >> RECIP_SHIFT, exact for x < 2**30 / 6
   localparam int RECIP_SHIFT = 30;
   localparam logic [NUMBER_BITS-1:0] RECIP_TEN = NUMBER_BITS'(107374183);
   localparam int PROD_BITS = 64;

   localparam logic [NUMBER_BITS-1:0] TEN_POW_5 = NUMBER_BITS'(100000);
   localparam logic [NUMBER_BITS-1:0] TEN_POW_6 = NUMBER_BITS'(1000000);
   localparam logic [NUMBER_BITS-1:0] TEN_POW_7 = NUMBER_BITS'(10000000);
   localparam logic [NUMBER_BITS-1:0] TEN_POW_8 = NUMBER_BITS'(100000000);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_A = 2'd0,
      KIND_B = 2'd1,
      KIND_C = 2'd2
   } luhn_kind_type;

   typedef enum logic [1:0] {
      STATUS_VALID    = 2'd0,
      STATUS_LENGTH   = 2'd1,
      STATUS_CHECKSUM = 2'd2
   } luhn_status_type;

   typedef struct packed {
      logic                   len_ok;
      logic [NUMBER_BITS-1:0] rest;
      logic [TOTAL_BITS-1:0]  total;
   } luhn_stage_type;

   function automatic logic length_matches(input logic [KIND_BITS-1:0] kind,
                                           input logic [NUMBER_BITS-1:0] num);
      logic ok;
      ok = 1'b0;
      unique case (kind)
         KIND_A:  ok = (num >= TEN_POW_7) && (num < TEN_POW_8);
         KIND_B:  ok = (num >= TEN_POW_6) && (num < TEN_POW_7);
         KIND_C:  ok = (num >= TEN_POW_5) && (num < TEN_POW_6);
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic logic [DIGIT_BITS-1:0] luhn_double(input logic [DIGIT_BITS-1:0] dig);
      logic [DIGIT_BITS:0] dbl;
      dbl = {dig, 1'b0};
      if (dbl > 5'd9) begin
         dbl = dbl - 5'd9;
      end
      return dbl[DIGIT_BITS-1:0];
   endfunction

   function automatic logic [DIGIT_BITS-1:0] mod_ten(input logic [TOTAL_BITS-1:0] t);
      logic [TOTAL_BITS-1:0] r;
      priority if (t >= 7'd70) r = t - 7'd70;
      else if (t >= 7'd60) r = t - 7'd60;
      else if (t >= 7'd50) r = t - 7'd50;
      else if (t >= 7'd40) r = t - 7'd40;
      else if (t >= 7'd30) r = t - 7'd30;
      else if (t >= 7'd20) r = t - 7'd20;
      else if (t >= 7'd10) r = t - 7'd10;
      else                 r = t;
      return r[DIGIT_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

[design/luhn_if.sv]
// Request and response channel interfaces for the Luhn checker.
// Depends on luhn_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface luhn_req_if;
   import luhn_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [KIND_BITS-1:0]   card_kind;
   logic [NUMBER_BITS-1:0] card_value;
   modport source (output valid, output card_kind, output card_value, input ready);
   modport sink   (input valid, input card_kind, input card_value, output ready);
endinterface

interface luhn_rsp_if;
   import luhn_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  length_ok;
   logic [TOTAL_BITS-1:0] luhn_total;
   logic [DIGIT_BITS-1:0] total_last_digit;
   logic [1:0]            check_status;
   modport source (output valid, output length_ok, output luhn_total,
                   output total_last_digit, output check_status, input ready);
   modport sink   (input valid, input length_ok, input luhn_total,
                   input total_last_digit, input check_status, output ready);
endinterface
`default_nettype wire

[design/card_number_luhn_check.sv]
// Top level of the card number Luhn checker: input register, digit stages,
// result register. Depends on luhn_pkg, luhn_if and the three stage modules.
//
//   channel   direction  payload
//   req_chan  in         card_kind, card_value
//   rsp_chan  out        length_ok, luhn_total, total_last_digit, check_status
//
// One request per cycle sustained while the response side is ready; a request passes
// the input register, eight digit stages (one decimal digit each, a reciprocal multiply by ten)
// and the result register. Every stage holds its own valid bit, so bubbles
// close up and a stalled response still lets earlier stages fill.
// Reset is synchronous and clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module card_number_luhn_check (
   input  wire logic  clock,
   input  wire logic  reset,
   luhn_req_if.sink   req_chan,
   luhn_rsp_if.source rsp_chan
);
   import luhn_pkg::*;

   logic           stage_valid [DIGITS+1];
   logic           stage_ready [DIGITS+1];
   luhn_stage_type stage_data  [DIGITS+1];

   luhn_input_stage u_input (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .dn_valid (stage_valid[0]),
      .dn_ready (stage_ready[0]),
      .dn_data  (stage_data[0])
   );

   for (genvar g = 0; g < DIGITS; g++) begin : g_digit
      luhn_digit_stage u_digit (
         .clock        (clock),
         .reset        (reset),
         .double_digit ((g % 2) == 1),
         .up_valid     (stage_valid[g]),
         .up_ready     (stage_ready[g]),
         .up_data      (stage_data[g]),
         .dn_valid     (stage_valid[g+1]),
         .dn_ready     (stage_ready[g+1]),
         .dn_data      (stage_data[g+1])
      );
   end

   luhn_result_stage u_result (
      .clock    (clock),
      .reset    (reset),
      .up_valid (stage_valid[DIGITS]),
      .up_ready (stage_ready[DIGITS]),
      .up_data  (stage_data[DIGITS]),
      .rsp_chan (rsp_chan)
   );
endmodule
`default_nettype wire

[design/luhn_input_stage.sv]
// Input register: latches the request and its digit-count check.
// Depends on luhn_pkg and luhn_req_if.
`timescale 1ns / 1ps
`default_nettype none
module luhn_input_stage (
   input  wire logic                     clock,
   input  wire logic                     reset,
   luhn_req_if.sink                      req_chan,
   output      logic                     dn_valid,
   input  wire logic                     dn_ready,
   output      luhn_pkg::luhn_stage_type dn_data
);
   import luhn_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   luhn_stage_type data_ff;
   luhn_stage_type data_in;
   logic           take;

   assign req_chan.ready = !valid_ff || dn_ready;
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in       = req_chan.ready ? req_chan.valid : valid_ff;
      data_in.len_ok = length_matches(req_chan.card_kind, req_chan.card_value);
      data_in.rest   = req_chan.card_value;
      data_in.total  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;
endmodule
`default_nettype wire

[design/luhn_digit_stage.sv]
// One digit stage: peel the lowest decimal digit and add its Luhn weight.
// Depends on luhn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module luhn_digit_stage (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     double_digit,
   input  wire logic                     up_valid,
   output      logic                     up_ready,
   input  wire luhn_pkg::luhn_stage_type up_data,
   output      logic                     dn_valid,
   input  wire logic                     dn_ready,
   output      luhn_pkg::luhn_stage_type dn_data
);
   import luhn_pkg::*;

   logic                   valid_ff;
   logic                   valid_in;
   luhn_stage_type         data_ff;
   luhn_stage_type         data_in;
   logic [PROD_BITS-1:0]   product;
   logic [NUMBER_BITS-1:0] quot;
   logic [NUMBER_BITS-1:0] ten_quot;
   logic [NUMBER_BITS-1:0] diff;
   logic [DIGIT_BITS-1:0]  dig;
   logic [DIGIT_BITS-1:0]  weight;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      product  = PROD_BITS'(up_data.rest) * PROD_BITS'(RECIP_TEN);
      quot     = product[RECIP_SHIFT +: NUMBER_BITS];
      ten_quot = (quot << 3) + (quot << 1);
      diff     = up_data.rest - ten_quot;
      dig      = diff[DIGIT_BITS-1:0];
      weight   = double_digit ? luhn_double(dig) : dig;
      data_in.len_ok = up_data.len_ok;
      data_in.rest   = quot;
      data_in.total  = up_data.total + TOTAL_BITS'(weight);
      valid_in = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;
endmodule
`default_nettype wire

[design/luhn_result_stage.sv]
// Result register: forms last digit and status, drives the response channel.
// Depends on luhn_pkg and luhn_rsp_if.
`timescale 1ns / 1ps
`default_nettype none
module luhn_result_stage (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     up_valid,
   output      logic                     up_ready,
   input  wire luhn_pkg::luhn_stage_type up_data,
   luhn_rsp_if.source                    rsp_chan
);
   import luhn_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic                  len_ok_ff;
   logic [TOTAL_BITS-1:0] total_ff;
   logic [TOTAL_BITS-1:0] total_in;
   logic [DIGIT_BITS-1:0] last_ff;
   logic [DIGIT_BITS-1:0] last_in;
   luhn_status_type       status_ff;
   luhn_status_type       status_in;

   assign up_ready = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = up_ready ? up_valid : valid_ff;
      total_in = up_data.len_ok ? up_data.total : '0;
      last_in  = mod_ten(total_in);
      if (!up_data.len_ok) begin
         status_in = STATUS_LENGTH;
      end else if (last_in == '0) begin
         status_in = STATUS_VALID;
      end else begin
         status_in = STATUS_CHECKSUM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         len_ok_ff <= up_data.len_ok;
         total_ff  <= total_in;
         last_ff   <= last_in;
         status_ff <= status_in;
      end
   end

   assign rsp_chan.valid            = valid_ff;
   assign rsp_chan.length_ok        = len_ok_ff;
   assign rsp_chan.luhn_total       = total_ff;
   assign rsp_chan.total_last_digit = last_ff;
   assign rsp_chan.check_status     = status_ff;
endmodule
`default_nettype wire

[verif/card_number_luhn_check_tb.sv]
// Testbench for card_number_luhn_check: random and directed card requests, self-checked
// against an in-bench Luhn predictor. Depends on luhn_pkg and the luhn_req_if / luhn_rsp_if
// interfaces of the design.
`timescale 1ns / 1ps
module card_number_luhn_check_tb;
   import luhn_pkg::*;

   localparam logic [KIND_BITS-1:0] KIND_UNDEF = 2'd3;
   localparam int RANDOM_REQUESTS = 1350;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 12;
   localparam int STALL_CYCLES    = 80;
   localparam int STALL_AFTER     = 100;
   localparam int NUMBER_MAX      = (1 << NUMBER_BITS) - 1;

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic [NUMBER_BITS-1:0] value;
   } card_req_type;

   typedef struct {
      logic                  length_ok;
      logic [TOTAL_BITS-1:0] luhn_total;
      logic [DIGIT_BITS-1:0] total_last_digit;
      luhn_status_type       check_status;
   } card_verdict_type;

   logic clock;
   logic reset;
   luhn_req_if req_chan ();
   luhn_rsp_if rsp_chan ();

   card_number_luhn_check dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   card_req_type     pending_cards[$];
   card_verdict_type expected_verdicts[$];
   int               mismatches;
   int               responses_seen;
   int               cycle_count;
   int               stall_left;
   logic             stall_done;
   logic             req_fire;
   wire              quiet_window = (cycle_count >= 700) && (cycle_count < 1100);

   function automatic int unsigned luhn_digit_sum(input logic [NUMBER_BITS-1:0] value);
      int unsigned rest;
      int unsigned dig;
      int unsigned dbl;
      int unsigned sum;
      rest = 32'(value);
      sum  = 0;
      for (int p = 0; p < DIGITS; p++) begin
         dig = rest % 10;
         if (p % 2 == 1) begin
            dbl = dig * 2;
            sum += (dbl > 9) ? dbl - 9 : dbl;
         end else begin
            sum += dig;
         end
         rest /= 10;
      end
      return sum;
   endfunction

   function automatic card_verdict_type grade_card(input logic [KIND_BITS-1:0] kind,
                                                   input logic [NUMBER_BITS-1:0] value);
      card_verdict_type v;
      logic             fits;
      int unsigned      sum;
      case (kind)
         KIND_A:  fits = (value >= TEN_POW_7) && (value < TEN_POW_8);
         KIND_B:  fits = (value >= TEN_POW_6) && (value < TEN_POW_7);
         KIND_C:  fits = (value >= TEN_POW_5) && (value < TEN_POW_6);
         default: fits = 1'b0;
      endcase
      v.length_ok        = fits;
      v.luhn_total       = '0;
      v.total_last_digit = '0;
      v.check_status     = STATUS_LENGTH;
      if (fits) begin
         sum                = luhn_digit_sum(value);
         v.luhn_total       = TOTAL_BITS'(sum);
         v.total_last_digit = DIGIT_BITS'(sum % 10);
         v.check_status     = (sum % 10 == 0) ? STATUS_VALID : STATUS_CHECKSUM;
      end
      return v;
   endfunction

   function automatic int places_for(input logic [KIND_BITS-1:0] kind);
      case (kind)
         KIND_A:  return 8;
         KIND_B:  return 7;
         KIND_C:  return 6;
         default: return 8;
      endcase
   endfunction

   function automatic logic [NUMBER_BITS-1:0] digits_in_span(input int places);
      int unsigned lo;
      int unsigned hi;
      lo = 1;
      repeat (places - 1) lo *= 10;
      hi = lo * 10 - 1;
      if (places == 1) lo = 0;
      if (hi > NUMBER_MAX) hi = NUMBER_MAX;
      return NUMBER_BITS'($urandom_range(hi, lo));
   endfunction

   // fix the units digit so the Luhn sum lands on a multiple of ten
   function automatic logic [NUMBER_BITS-1:0] luhn_valid_number(input int places);
      logic [NUMBER_BITS-1:0] v;
      v = digits_in_span(places);
      v = v - NUMBER_BITS'(v % 10);
      return v + NUMBER_BITS'((10 - luhn_digit_sum(v) % 10) % 10);
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin : monitor
      card_verdict_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            expected_verdicts.push_back(grade_card(req_chan.card_kind, req_chan.card_value));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            responses_seen++;
            if (expected_verdicts.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, expected none actual status %0d",
                        $time, rsp_chan.check_status);
            end else begin
               want = expected_verdicts.pop_front();
               check_field("length_ok", want.length_ok, rsp_chan.length_ok);
               check_field("luhn_total", want.luhn_total, rsp_chan.luhn_total);
               check_field("total_last_digit", want.total_last_digit,
                           rsp_chan.total_last_digit);
               check_field("check_status", want.check_status, rsp_chan.check_status);
            end
         end
      end
      req_fire <= !reset && req_chan.valid && req_chan.ready;
   end

   always @(negedge clock) begin : driver
      card_req_type next_card;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_fire) begin
         if (pending_cards.size() != 0 && (quiet_window || $urandom_range(99) >= 9)) begin
            next_card = pending_cards.pop_front();
            req_chan.valid      <= 1'b1;
            req_chan.card_kind  <= next_card.kind;
            req_chan.card_value <= next_card.value;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // hold off the response side once so the pipeline backs up into the request side
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else if (!stall_done && responses_seen >= STALL_AFTER) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= STALL_CYCLES;
         stall_done     <= 1'b1;
      end else begin
         rsp_chan.ready <= quiet_window || ($urandom_range(99) >= 9);
      end
   end

   initial begin
      int          roll;
      logic [1:0]  kind;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.card_kind  = '0;
      req_chan.card_value = '0;
      rsp_chan.ready      = 1'b0;
      mismatches          = 0;
      responses_seen      = 0;
      cycle_count         = 0;
      stall_left          = 0;
      stall_done          = 1'b0;
      req_fire            = 1'b0;

      pending_cards.push_back('{KIND_A, NUMBER_BITS'(TEN_POW_7 - 1)});
      pending_cards.push_back('{KIND_A, TEN_POW_7});
      pending_cards.push_back('{KIND_A, NUMBER_BITS'(TEN_POW_8 - 1)});
      pending_cards.push_back('{KIND_A, TEN_POW_8});
      pending_cards.push_back('{KIND_B, NUMBER_BITS'(TEN_POW_6 - 1)});
      pending_cards.push_back('{KIND_B, TEN_POW_6});
      pending_cards.push_back('{KIND_B, NUMBER_BITS'(TEN_POW_7 - 1)});
      pending_cards.push_back('{KIND_B, TEN_POW_7});
      pending_cards.push_back('{KIND_C, NUMBER_BITS'(TEN_POW_5 - 1)});
      pending_cards.push_back('{KIND_C, TEN_POW_5});
      pending_cards.push_back('{KIND_C, NUMBER_BITS'(TEN_POW_6 - 1)});
      pending_cards.push_back('{KIND_C, TEN_POW_6});
      pending_cards.push_back('{KIND_A, luhn_valid_number(8)});
      pending_cards.push_back('{KIND_B, luhn_valid_number(7)});
      pending_cards.push_back('{KIND_C, luhn_valid_number(6)});
      pending_cards.push_back('{KIND_UNDEF, luhn_valid_number(8)});
      pending_cards.push_back('{KIND_UNDEF, NUMBER_BITS'(NUMBER_MAX)});
      pending_cards.push_back('{KIND_A, NUMBER_BITS'(0)});
      pending_cards.push_back('{KIND_A, NUMBER_BITS'(NUMBER_MAX)});
      pending_cards.push_back('{KIND_C, NUMBER_BITS'(0)});

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         roll = $urandom_range(99);
         kind = 2'($urandom_range(2));
         if (roll < 40) begin
            pending_cards.push_back('{kind, luhn_valid_number(places_for(kind))});
         end else if (roll < 75) begin
            pending_cards.push_back('{kind, digits_in_span(places_for(kind))});
         end else if (roll < 88) begin
            pending_cards.push_back('{2'($urandom_range(3)),
                                      digits_in_span($urandom_range(9, 1))});
         end else begin
            pending_cards.push_back('{2'($urandom_range(3)),
                                      NUMBER_BITS'($urandom_range(NUMBER_MAX))});
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_cards.size() != 0 || req_chan.valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_verdicts.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
